// ----- hdl/taes_pkg.sv -----
// Types, constants and byte-level functions shared by the tweakable AES unit.
package taes_pkg;

    typedef logic [15:0][7:0]  t_blk;
    typedef logic [255:0][7:0] t_tab;

    typedef enum logic [2:0] {
        ST_EXPAND,
        ST_IDLE,
        ST_INIT,
        ST_RUN
    } t_state;

    localparam logic OP_ENC = 1'b0;
    localparam logic OP_DEC = 1'b1;

    localparam int unsigned ADDR_W = 4;
    localparam logic [ADDR_W-1:0] ADDR_KEY_LO = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_KEY_HI = 4'h8;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a_in, input logic [7:0] b_in);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] r;
        a = a_in;
        b = b_in;
        r = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) r = r ^ a;
            a = xtime(a);
            b = b >> 1;
        end
        return r;
    endfunction

    function automatic t_tab gen_sbox();
        t_tab       tb;
        logic [7:0] inv;
        logic [7:0] base;
        for (int x = 0; x < 256; x++) begin
            inv  = 8'h01;
            base = 8'(x);
            for (int e = 0; e < 8; e++) begin
                if (((254 >> e) & 1) != 0) inv = gf_mul(inv, base);
                base = gf_mul(base, base);
            end
            if (x == 0) inv = 8'h00;
            tb[x] = inv ^ 8'h63 ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                  ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]};
        end
        return tb;
    endfunction

    localparam t_tab SBOX = gen_sbox();

    function automatic t_tab gen_isbox();
        t_tab tb;
        for (int x = 0; x < 256; x++) tb[SBOX[x]] = 8'(x);
        return tb;
    endfunction

    localparam t_tab ISBOX = gen_isbox();

    function automatic logic [7:0] rcon(input int unsigned idx);
        return 8'(1 << (idx - 1));
    endfunction

    // ShiftRows then SubBytes
    function automatic t_blk sub_shift(input t_blk s);
        t_blk t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[4*c+r] = SBOX[s[4*((c+r)&3)+r]];
        return t;
    endfunction

    function automatic t_blk inv_sub_shift(input t_blk s);
        t_blk t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[4*((c+r)&3)+r] = ISBOX[s[4*c+r]];
        return t;
    endfunction

    function automatic t_blk mix(input t_blk s);
        t_blk t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
            t[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return t;
    endfunction

    function automatic t_blk inv_mix(input t_blk s);
        t_blk t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
            t[4*c]   = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13)
                     ^ gf_mul(a3, 8'd9);
            t[4*c+1] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11)
                     ^ gf_mul(a3, 8'd13);
            t[4*c+2] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14)
                     ^ gf_mul(a3, 8'd11);
            t[4*c+3] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9)
                     ^ gf_mul(a3, 8'd14);
        end
        return t;
    endfunction

    // One step of the AES-128 key schedule
    function automatic t_blk key_step(input t_blk k_in, input logic [7:0] rc);
        t_blk k;
        k = k_in;
        k[0] = k[0] ^ SBOX[k[13]] ^ rc;
        k[1] = k[1] ^ SBOX[k[14]];
        k[2] = k[2] ^ SBOX[k[15]];
        k[3] = k[3] ^ SBOX[k[12]];
        for (int i = 4; i < 16; i++) k[i] = k[i] ^ k[i-4];
        return k;
    endfunction

endpackage

// ----- hdl/tweakable_aes_block_cipher_unit.sv -----
// Tweakable reduced-round AES unit: key schedule, shared round datapath, APB key port.
// Order: the request is registered at acceptance, then a whitening step, then the round steps;
//   a full-count request runs every round, a short count fewer; a stalled output holds the last step.
// Requests are taken one at a time (ready only while idle), since a single round unit serves them.
// Reset (synchronous, active low) clears the key to zero and runs the key schedule before the
//   first request is taken; every key write reruns it.
module tweakable_aes_block_cipher_unit #(
    parameter int unsigned ROUNDS = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request stream
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // [63:0] data_low, [127:64] data_high, [191:128] tweak_low,
    // [255:192] tweak_high, [258:256] round_count, [263:259] zero
    input  logic [263:0]                 i_s_axis_tdata,
    // [0] opcode
    input  logic                         i_s_axis_tuser,
    // result stream
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // [63:0] result_low, [127:64] result_high
    output logic [127:0]                 o_m_axis_tdata,
    // APB key port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [taes_pkg::ADDR_W-1:0]  paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready
);
    import taes_pkg::*;

    localparam int unsigned IW = $clog2(ROUNDS + 1);
    localparam logic [IW-1:0] LAST = IW'(ROUNDS);

    t_state      r_st, n_st;
    logic [63:0] r_key_lo, r_key_hi;
    t_blk        r_kx;
    logic [IW-1:0] r_ex;
    t_blk        r_rk [0:ROUNDS];

    t_blk          r_s, n_s;
    t_blk          r_t;
    logic          r_op;
    logic          r_full;
    logic [IW-1:0] r_first;
    logic [IW-1:0] r_i, n_i;
    logic          r_ov;
    t_blk          r_out;

    logic          cfg_wr, s_acc, can_out, fin;
    logic [2:0]    cnt_sat;
    logic [IW-1:0] ka;
    t_blk          k, kt, dss, im_in, im_out, enc_out;

    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    always_comb begin
        priority if (paddr == ADDR_KEY_LO) prdata = r_key_lo;
        else if (paddr == ADDR_KEY_HI)     prdata = r_key_hi;
        else                               prdata = '0;
    end

    assign o_s_axis_tready = (r_st == ST_IDLE) & ~cfg_wr;
    assign s_acc   = i_s_axis_tvalid & o_s_axis_tready;
    assign can_out = ~r_ov | i_m_axis_tready;
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_out;

    // requested rounds, saturated
    assign cnt_sat = (i_s_axis_tdata[258:256] > 3'(ROUNDS)) ? 3'(ROUNDS)
                                                            : i_s_axis_tdata[258:256];

    // round key selection: whitening key in the load step, r_i while rounds run
    always_comb begin
        if (r_st == ST_INIT) begin
            if (r_op == OP_DEC) ka = LAST;
            else                ka = r_full ? IW'(0) : IW'(1);
        end else begin
            ka = r_i;
        end
    end

    assign k       = r_rk[ka];
    assign kt      = k ^ r_t;
    assign enc_out = mix(sub_shift(r_s)) ^ kt;
    assign dss     = inv_sub_shift(r_s);
    // one state-side InvMixColumns, shared by the decrypt load step and the rounds
    assign im_in   = (r_st == ST_INIT) ? (r_s ^ kt) : dss;
    assign im_out  = inv_mix(im_in);

    // datapath step
    always_comb begin
        n_s = r_s;
        n_i = r_i;
        fin = 1'b0;
        unique case (r_st)
            ST_INIT: begin
                if (r_op == OP_DEC) begin
                    n_s = im_out;
                    n_i = (r_first == LAST) ? LAST : IW'(ROUNDS - 1);
                end else if (r_full) begin
                    n_s = r_s ^ kt;
                    n_i = IW'(1);
                end else begin
                    n_s = r_s ^ k;
                    n_i = IW'(2);
                    fin = (ROUNDS == 1);
                end
            end
            ST_RUN: begin
                if (r_op == OP_DEC) begin
                    if (r_i == r_first) begin
                        n_s = dss ^ kt;
                        fin = 1'b1;
                    end else begin
                        // InvMixColumns is linear: InvMix(k) ^ InvMix(t) = InvMix(k ^ t)
                        n_s = im_out ^ inv_mix(kt);
                        n_i = r_i - IW'(1);
                    end
                end else begin
                    n_s = enc_out;
                    if (r_i == LAST) fin = 1'b1;
                    else             n_i = r_i + IW'(1);
                end
            end
            default: begin
                n_s = r_s;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_EXPAND: if (r_ex == LAST) n_st = ST_IDLE;
            ST_IDLE: begin
                if (cfg_wr)     n_st = ST_EXPAND;
                else if (s_acc) n_st = ST_INIT;
            end
            ST_INIT: begin
                if (fin) begin
                    if (can_out) n_st = ST_IDLE;
                end else begin
                    n_st = ST_RUN;
                end
            end
            ST_RUN: if (fin && can_out) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
        if (cfg_wr) n_st = ST_EXPAND;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_EXPAND;
            r_ex     <= '0;
            r_ov     <= 1'b0;
            r_key_lo <= '0;
            r_key_hi <= '0;
        end else begin
            r_st <= n_st;
            if (cfg_wr && paddr == ADDR_KEY_LO) r_key_lo <= pwdata;
            if (cfg_wr && paddr == ADDR_KEY_HI) r_key_hi <= pwdata;
            if (cfg_wr)                 r_ex <= '0;
            else if (r_st == ST_EXPAND) r_ex <= r_ex + IW'(1);
            if (fin && can_out)         r_ov <= 1'b1;
            else if (i_m_axis_tready)   r_ov <= 1'b0;
        end
    end

    // key schedule, one round key a cycle, restarted by any key write
    always_ff @(posedge i_clk) begin
        if (r_st == ST_EXPAND && !cfg_wr) begin
            if (r_ex == '0) begin
                r_kx    <= {r_key_hi, r_key_lo};
                r_rk[0] <= {r_key_hi, r_key_lo};
            end else begin
                r_kx       <= key_step(r_kx, rcon(int'(r_ex)));
                r_rk[r_ex] <= key_step(r_kx, rcon(int'(r_ex)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s     <= i_s_axis_tdata[127:0];
            r_t     <= i_s_axis_tdata[255:128];
            r_op    <= i_s_axis_tuser;
            r_full  <= (cnt_sat == 3'(ROUNDS));
            r_first <= IW'(3'(ROUNDS) - cnt_sat);
        end else if ((r_st == ST_INIT || r_st == ST_RUN) && (!fin || can_out)) begin
            r_s <= n_s;
            r_i <= n_i;
        end
        if (fin && can_out) r_out <= n_s;
    end

    a_key_write_expands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_st == ST_EXPAND && r_ex == '0))
        else $error("key write did not restart the schedule");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_st == ST_INIT))
        else $error("accepted request not loaded");

    a_dec_index_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_RUN && r_op == OP_DEC) |-> (r_i >= r_first))
        else $error("decrypt round index passed its last round");

    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_EXPAND || r_st == ST_RUN) |-> !o_s_axis_tready)
        else $error("ready while busy");

endmodule
